// ===== src/cscalc_pkg.sv =====
package cscalc_pkg;

   // PLL fractional denominator
   localparam logic [19:0] FRAC_DENOM = 20'hFFFFF;
   localparam logic [7:0]  RESET_WORD = 8'hA0;
   localparam logic [7:0]  CTRL_WORD  = 8'h4F;
   localparam logic [4:0]  LAST_WRITE = 5'd17;

   localparam logic [0:0] CSR_CRYSTAL = 1'b0;
   localparam logic [0:0] CSR_VCO     = 1'b1;

   // one computed setting, queued between front and back
   typedef struct packed {
      logic [17:0] p1;
      logic [19:0] p2;
      logic [17:0] q1;
   } calc_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ===== src/cscalc_front.sv =====
module cscalc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [27:0]         frequency,
   input  logic [25:0]         crystal_freq,
   input  logic [29:0]         vco_target,
   input  cscalc_pkg::qstat_type qstat,
   output logic                push,
   output cscalc_pkg::calc_type push_data
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIV1  = 4'd1;
   localparam logic [3:0] S_MUL   = 4'd2;
   localparam logic [3:0] S_LOAD2 = 4'd3;
   localparam logic [3:0] S_DIV2  = 4'd4;
   localparam logic [3:0] S_LOAD3 = 4'd5;
   localparam logic [3:0] S_DIV3  = 4'd6;
   localparam logic [3:0] S_TCALC = 4'd7;
   localparam logic [3:0] S_PUSH  = 4'd8;

   logic [3:0]  state_ff, state_in;
   logic [27:0] freq_ff, freq_in;
   logic [29:0] rem_ff, rem_in;
   logic [29:0] quo_ff, quo_in;
   logic [29:0] dvd_ff, dvd_in;
   logic [29:0] dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [29:0] d_ff, d_in;
   logic [29:0] pll_ff, pll_in;
   logic [7:0]  m_ff, m_in;
   logic [19:0] n_ff, n_in;
   cscalc_pkg::calc_type entry_ff, entry_in;

   logic [30:0] shift;
   logic        ge;
   logic [30:0] diff;
   logic [29:0] rem_step;
   logic [29:0] quo_step;
   logic [57:0] prod_mul;
   logic [45:0] prod_frac;
   logic [26:0] x128;
   logic [20:0] rsum;
   logic [20:0] tr;
   logic [6:0]  t;

   // one restoring division step
   always_comb begin
      shift    = {rem_ff, dvd_ff[29]};
      diff     = shift - {1'b0, dvs_ff};
      ge       = shift >= {1'b0, dvs_ff};
      rem_step = ge ? diff[29:0] : shift[29:0];
      quo_step = {quo_ff[28:0], ge};
   end

   assign prod_mul  = d_ff * freq_ff;
   assign prod_frac = {rem_ff[25:0], 20'b0} - {20'b0, rem_ff[25:0]};

   // t = floor(128*N/denom), remainder gives P2
   // denom is 2^20-1: x = hi*denom + hi + lo, so at most one correction
   assign x128 = {n_ff, 7'b0};
   always_comb begin
      rsum = {1'b0, x128[19:0]} + {14'b0, x128[26:20]};
      if (rsum >= {1'b0, cscalc_pkg::FRAC_DENOM}) begin
         t  = x128[26:20] + 7'd1;
         tr = rsum - {1'b0, cscalc_pkg::FRAC_DENOM};
      end else begin
         t  = x128[26:20];
         tr = rsum;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      freq_in  = freq_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvd_in   = dvd_ff;
      dvs_in   = dvs_ff;
      cnt_in   = cnt_ff;
      d_in     = d_ff;
      pll_in   = pll_ff;
      m_in     = m_ff;
      n_in     = n_ff;
      entry_in = entry_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               freq_in = frequency;
               rem_in  = '0;
               quo_in  = '0;
               dvd_in  = vco_target;
               dvs_in  = {2'b0, frequency};
               cnt_in  = 5'd29;
               if (frequency == '0) begin
                  d_in     = '0;
                  state_in = S_MUL;
               end else begin
                  state_in = S_DIV1;
               end
            end
         end
         S_DIV1: begin
            rem_in = rem_step;
            quo_in = quo_step;
            dvd_in = {dvd_ff[28:0], 1'b0};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               d_in     = {quo_step[29:1], 1'b0};
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            pll_in   = prod_mul[29:0];
            state_in = S_LOAD2;
         end
         S_LOAD2: begin
            rem_in = '0;
            quo_in = '0;
            dvd_in = pll_ff;
            dvs_in = {4'b0, crystal_freq};
            cnt_in = 5'd29;
            if (crystal_freq == '0) begin
               m_in     = '0;
               n_in     = '0;
               state_in = S_TCALC;
            end else begin
               state_in = S_DIV2;
            end
         end
         S_DIV2: begin
            rem_in = rem_step;
            quo_in = quo_step;
            dvd_in = {dvd_ff[28:0], 1'b0};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               m_in     = quo_step[7:0];
               state_in = S_LOAD3;
            end
         end
         S_LOAD3: begin
            // top bits of rem*denom already sit below the crystal value
            rem_in   = {4'b0, prod_frac[45:20]};
            dvd_in   = {prod_frac[19:0], 10'b0};
            quo_in   = '0;
            cnt_in   = 5'd19;
            state_in = S_DIV3;
         end
         S_DIV3: begin
            rem_in = rem_step;
            quo_in = quo_step;
            dvd_in = {dvd_ff[28:0], 1'b0};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               n_in     = quo_step[19:0];
               state_in = S_TCALC;
            end
         end
         S_TCALC: begin
            entry_in.p1 = {3'b0, m_ff, 7'b0} + {11'b0, t} - 18'd512;
            entry_in.p2 = tr[19:0];
            entry_in.q1 = {d_ff[10:0], 7'b0} - 18'd512;
            state_in    = S_PUSH;
         end
         S_PUSH: begin
            if (!qstat.full) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      freq_ff  <= freq_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvd_ff   <= dvd_in;
      dvs_ff   <= dvs_in;
      cnt_ff   <= cnt_in;
      d_ff     <= d_in;
      pll_ff   <= pll_in;
      m_ff     <= m_in;
      n_ff     <= n_in;
      entry_ff <= entry_in;
   end

   assign busy      = state_ff != S_IDLE;
   assign push      = (state_ff == S_PUSH) && !qstat.full;
   assign push_data = entry_ff;

endmodule

// ===== src/cscalc_queue.sv =====
module cscalc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cscalc_pkg::calc_type push_data,
   input  logic                 pop,
   output cscalc_pkg::calc_type pop_data,
   output cscalc_pkg::qstat_type qstat
);

   cscalc_pkg::calc_type mem_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] count_ff, count_in;

   // two-entry queue
   always_comb begin
      wp_in    = push ? ~wp_ff : wp_ff;
      rp_in    = pop ? ~rp_ff : rp_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= 1'b0;
         rp_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

   assign pop_data    = mem_ff[rp_ff];
   assign qstat.full  = count_ff == 2'd2;
   assign qstat.empty = count_ff == 2'd0;

endmodule

// ===== src/cscalc_back.sv =====
module cscalc_back #(
   parameter logic [7:0] PLL_BASE_REG  = 8'd26,
   parameter logic [7:0] MS_BASE_REG   = 8'd42,
   parameter logic [7:0] PLL_RESET_REG = 8'd177,
   parameter logic [7:0] CLK_CTRL_REG  = 8'd16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cscalc_pkg::qstat_type qstat,
   input  cscalc_pkg::calc_type  pop_data,
   output logic                  pop,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_reg_addr,
   output logic [7:0]            rsp_reg_data,
   output logic                  rsp_last
);

   logic       active_ff, active_in;
   logic [4:0] cnt_ff, cnt_in;
   cscalc_pkg::calc_type entry_ff, entry_in;
   logic       valid_ff;
   logic [7:0] addr_ff, addr_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff;
   logic       done;

   assign done = active_ff && (cnt_ff == cscalc_pkg::LAST_WRITE);
   assign pop  = !qstat.empty && (!active_ff || done);

   // beat sequencing
   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff + 5'd1;
      entry_in  = entry_ff;
      if (pop) begin
         active_in = 1'b1;
         cnt_in    = '0;
         entry_in  = pop_data;
      end else if (done || !active_ff) begin
         active_in = 1'b0;
         cnt_in    = '0;
      end
   end

   // address and byte of the current beat
   always_comb begin
      addr_in = '0;
      data_in = '0;
      case (cnt_ff)
         5'd0:  begin addr_in = PLL_BASE_REG;         data_in = 8'hFF; end
         5'd1:  begin addr_in = PLL_BASE_REG + 8'd1;  data_in = 8'hFF; end
         5'd2:  begin addr_in = PLL_BASE_REG + 8'd2;  data_in = {6'b0, entry_ff.p1[17:16]}; end
         5'd3:  begin addr_in = PLL_BASE_REG + 8'd3;  data_in = entry_ff.p1[15:8]; end
         5'd4:  begin addr_in = PLL_BASE_REG + 8'd4;  data_in = entry_ff.p1[7:0]; end
         5'd5:  begin addr_in = PLL_BASE_REG + 8'd5;  data_in = {4'hF, entry_ff.p2[19:16]}; end
         5'd6:  begin addr_in = PLL_BASE_REG + 8'd6;  data_in = entry_ff.p2[15:8]; end
         5'd7:  begin addr_in = PLL_BASE_REG + 8'd7;  data_in = entry_ff.p2[7:0]; end
         5'd8:  begin addr_in = MS_BASE_REG;          data_in = 8'h00; end
         5'd9:  begin addr_in = MS_BASE_REG + 8'd1;   data_in = 8'h01; end
         5'd10: begin addr_in = MS_BASE_REG + 8'd2;   data_in = {6'b0, entry_ff.q1[17:16]}; end
         5'd11: begin addr_in = MS_BASE_REG + 8'd3;   data_in = entry_ff.q1[15:8]; end
         5'd12: begin addr_in = MS_BASE_REG + 8'd4;   data_in = entry_ff.q1[7:0]; end
         5'd13: begin addr_in = MS_BASE_REG + 8'd5;   data_in = 8'h00; end
         5'd14: begin addr_in = MS_BASE_REG + 8'd6;   data_in = 8'h00; end
         5'd15: begin addr_in = MS_BASE_REG + 8'd7;   data_in = 8'h00; end
         5'd16: begin addr_in = PLL_RESET_REG;        data_in = cscalc_pkg::RESET_WORD; end
         5'd17: begin addr_in = CLK_CTRL_REG;         data_in = cscalc_pkg::CTRL_WORD; end
         default: begin addr_in = '0;                 data_in = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
         valid_ff  <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
         valid_ff  <= active_ff;
         last_ff   <= done;
      end
      entry_ff <= entry_in;
      addr_ff  <= addr_in;
      data_ff  <= data_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_reg_addr = addr_ff;
   assign rsp_reg_data = data_ff;
   assign rsp_last     = last_ff;

endmodule

// ===== src/clock_synth_register_calc.sv =====
// Channel   Ports                                   Handshake
// request   req_frequency                           start & !busy
// result    rsp_reg_addr, rsp_reg_data, rsp_last    rsp_valid, one cycle
// config    csr_wen, csr_index, csr_wdata           csr_wen
//
// A request runs in the front through the shared
// radix-2 divider (30 + 30 + 20 steps), then 18 result beats in the back.
// The front takes a new request as soon as its result is queued, while
// earlier beats still go out. Each result beat is registered and goes out in the cycle after the back starts it.
// Reset is synchronous; it clears the control state and sets the configuration registers to their defaults.
// The receiver cannot stall; results are never held off.
module clock_synth_register_calc #(
   parameter logic [7:0] PLL_BASE_REG  = 8'd26,
   parameter logic [7:0] MS_BASE_REG   = 8'd42,
   parameter logic [7:0] PLL_RESET_REG = 8'd177,
   parameter logic [7:0] CLK_CTRL_REG  = 8'd16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [27:0] req_frequency,
   output logic        rsp_valid,
   output logic [7:0]  rsp_reg_addr,
   output logic [7:0]  rsp_reg_data,
   output logic        rsp_last,
   input  logic        csr_wen,
   input  logic [0:0]  csr_index,
   input  logic [29:0] csr_wdata
);

   logic [25:0] crystal_ff;
   logic [29:0] vco_ff;
   logic        push;
   logic        pop;
   cscalc_pkg::calc_type  push_data;
   cscalc_pkg::calc_type  pop_data;
   cscalc_pkg::qstat_type qstat;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         crystal_ff <= 26'd25000000;
         vco_ff     <= 30'd900000000;
      end else if (csr_wen) begin
         case (csr_index)
            cscalc_pkg::CSR_CRYSTAL: crystal_ff <= csr_wdata[25:0];
            cscalc_pkg::CSR_VCO:     vco_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   cscalc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .frequency    (req_frequency),
      .crystal_freq (crystal_ff),
      .vco_target   (vco_ff),
      .qstat        (qstat),
      .push         (push),
      .push_data    (push_data)
   );

   cscalc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   cscalc_back #(
      .PLL_BASE_REG  (PLL_BASE_REG),
      .MS_BASE_REG   (MS_BASE_REG),
      .PLL_RESET_REG (PLL_RESET_REG),
      .CLK_CTRL_REG  (CLK_CTRL_REG)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .qstat        (qstat),
      .pop_data     (pop_data),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_reg_addr (rsp_reg_addr),
      .rsp_reg_data (rsp_reg_data),
      .rsp_last     (rsp_last)
   );

   // last beat is always a valid beat to the control register
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> (rsp_valid && rsp_reg_addr == CLK_CTRL_REG))
      else $error("last beat malformed");

   // an accepted request keeps the front busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted without going busy");

   // no push into a full queue, no pop from an empty one
   a_queue_safe: assert property (@(posedge clock) disable iff (reset)
      !(push && qstat.full) && !(pop && qstat.empty))
      else $error("queue overrun or underrun");

endmodule
